[hw/rtl/bcc_pkg.sv]
// Shared widths, constants and types for the barycentric coordinate unit.
`timescale 1ns / 1ps
package bcc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 24;
  localparam int FIELD_W    = 16;
  localparam int WEIGHT_W   = 32;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int NUM_W   = CROSS_W + 2;
  localparam int MAG_W   = NUM_W;
  localparam int INT_BITS = WEIGHT_W - 1 - FRAC_BITS;
  localparam int STEPS   = INT_BITS + FRAC_BITS + 1;
  localparam int DIV_W   = MAG_W + INT_BITS;
  localparam int REM_W   = DIV_W + 1;

  localparam int FRONT_LAT = 6;
  localparam int LATENCY   = FRONT_LAT + STEPS + 1;

  localparam logic [WEIGHT_W-1:0] SAT_POS = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] SAT_NEG = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // Data handed from one divider cell to the next
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [STEPS-1:0] quo;
    logic             neg;
    logic             sat;
    logic             deg;
  } cell_t;

endpackage

[hw/rtl/bcc_front.sv]
// Edge vectors, cross products and divider setup for all three weights.
`timescale 1ns / 1ps
module bcc_front import bcc_pkg::*; (
  input  logic                clk,
  input  logic [FIELD_W-1:0]  ax,
  input  logic [FIELD_W-1:0]  ay,
  input  logic [FIELD_W-1:0]  bx,
  input  logic [FIELD_W-1:0]  by_coord,
  input  logic [FIELD_W-1:0]  cx,
  input  logic [FIELD_W-1:0]  cy,
  input  logic [FIELD_W-1:0]  px,
  input  logic [FIELD_W-1:0]  py,
  output cell_t               lane_a,
  output cell_t               lane_b,
  output cell_t               lane_c
);

  logic signed [COORD_BITS-1:0] rax, ray, rbx, rby, rcx, rcy, rpx, rpy;
  logic signed [DIFF_W-1:0]     e0x, e0y, e1x, e1y, e2x, e2y;
  logic signed [PROD_W-1:0]     p0, p1, p2, p3, p4, p5;
  logic signed [CROSS_W-1:0]    den, nb, nc;
  logic signed [NUM_W-1:0]      s4_den, s4_na, s4_nb, s4_nc;
  logic [MAG_W-1:0]             mag_d, mag_a, mag_b, mag_c;
  logic [DIV_W-1:0]             dvs;
  logic                         deg;

  // Capture coordinates, dropping bits above the coordinate width
  always_ff @(posedge clk) begin
    rax <= ax[COORD_BITS-1:0];
    ray <= ay[COORD_BITS-1:0];
    rbx <= bx[COORD_BITS-1:0];
    rby <= by_coord[COORD_BITS-1:0];
    rcx <= cx[COORD_BITS-1:0];
    rcy <= cy[COORD_BITS-1:0];
    rpx <= px[COORD_BITS-1:0];
    rpy <= py[COORD_BITS-1:0];
  end

  // Edge vectors from corner A
  always_ff @(posedge clk) begin
    e0x <= DIFF_W'(rbx) - DIFF_W'(rax);
    e0y <= DIFF_W'(rby) - DIFF_W'(ray);
    e1x <= DIFF_W'(rcx) - DIFF_W'(rax);
    e1y <= DIFF_W'(rcy) - DIFF_W'(ray);
    e2x <= DIFF_W'(rpx) - DIFF_W'(rax);
    e2y <= DIFF_W'(rpy) - DIFF_W'(ray);
  end

  // Cross product terms
  always_ff @(posedge clk) begin
    p0 <= e0x * e1y;
    p1 <= e0y * e1x;
    p2 <= e2x * e1y;
    p3 <= e2y * e1x;
    p4 <= e0x * e2y;
    p5 <= e0y * e2x;
  end

  always_ff @(posedge clk) begin
    den <= CROSS_W'(p0) - CROSS_W'(p1);
    nb  <= CROSS_W'(p2) - CROSS_W'(p3);
    nc  <= CROSS_W'(p4) - CROSS_W'(p5);
  end

  // Alpha numerator is what remains of the denominator
  always_ff @(posedge clk) begin
    s4_den <= NUM_W'(den);
    s4_nb  <= NUM_W'(nb);
    s4_nc  <= NUM_W'(nc);
    s4_na  <= NUM_W'(den) - NUM_W'(nb) - NUM_W'(nc);
  end

  always_comb begin
    mag_d = s4_den[NUM_W-1] ? MAG_W'(-s4_den) : MAG_W'(s4_den);
    mag_a = s4_na[NUM_W-1]  ? MAG_W'(-s4_na)  : MAG_W'(s4_na);
    mag_b = s4_nb[NUM_W-1]  ? MAG_W'(-s4_nb)  : MAG_W'(s4_nb);
    mag_c = s4_nc[NUM_W-1]  ? MAG_W'(-s4_nc)  : MAG_W'(s4_nc);
    dvs   = {mag_d, {INT_BITS{1'b0}}};
    deg   = (s4_den == '0);
  end

  // Seed the divider lanes; quotient overflow is known up front
  always_ff @(posedge clk) begin
    lane_a <= '{rem: REM_W'(mag_a), dvs: dvs, quo: '0,
                neg: s4_na[NUM_W-1] ^ s4_den[NUM_W-1],
                sat: DIV_W'(mag_a) >= dvs, deg: deg};
    lane_b <= '{rem: REM_W'(mag_b), dvs: dvs, quo: '0,
                neg: s4_nb[NUM_W-1] ^ s4_den[NUM_W-1],
                sat: DIV_W'(mag_b) >= dvs, deg: deg};
    lane_c <= '{rem: REM_W'(mag_c), dvs: dvs, quo: '0,
                neg: s4_nc[NUM_W-1] ^ s4_den[NUM_W-1],
                sat: DIV_W'(mag_c) >= dvs, deg: deg};
  end

endmodule

[hw/rtl/bcc_div_cell.sv]
// One restoring division step: produces one quotient bit per cycle.
`timescale 1ns / 1ps
module bcc_div_cell import bcc_pkg::*; (
  input  logic  clk,
  input  cell_t din,
  output cell_t dout
);

  logic [REM_W-1:0] rem2;
  logic             ge;

  // Double the remainder and try the subtract
  always_comb begin
    rem2 = {din.rem[REM_W-2:0], 1'b0};
    ge   = rem2 >= {1'b0, din.dvs};
  end

  always_ff @(posedge clk) begin
    dout.rem <= ge ? rem2 - {1'b0, din.dvs} : rem2;
    dout.dvs <= din.dvs;
    dout.quo <= {din.quo[STEPS-2:0], ge};
    dout.neg <= din.neg;
    dout.sat <= din.sat;
    dout.deg <= din.deg;
  end

endmodule

[hw/rtl/bcc_div_lane.sv]
// Chain of division cells for one weight, with rounding and saturation.
`timescale 1ns / 1ps
module bcc_div_lane import bcc_pkg::*; (
  input  logic                clk,
  input  cell_t               seed,
  output logic [WEIGHT_W-1:0] weight
);

  cell_t chain [STEPS+1];
  logic [WEIGHT_W:0]   inc;
  logic [WEIGHT_W-1:0] mag;
  logic [WEIGHT_W-1:0] weight_next;

  assign chain[0] = seed;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    bcc_div_cell u_cell (
      .clk  (clk),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Round half away from zero on the extra quotient bit, then clamp
  always_comb begin
    inc = {1'b0, chain[STEPS].quo} + (WEIGHT_W+1)'(1);
    mag = inc[WEIGHT_W:1];
    if (chain[STEPS].deg) begin
      weight_next = '0;
    end else if (chain[STEPS].neg) begin
      weight_next = chain[STEPS].sat ? SAT_NEG : -mag;
    end else begin
      weight_next = (chain[STEPS].sat || mag[WEIGHT_W-1]) ? SAT_POS : mag;
    end
  end

  always_ff @(posedge clk) begin
    weight <= weight_next;
  end

endmodule

[hw/rtl/triangle_barycentric_coords_unit.sv]
// Top level of the barycentric coordinate unit.
// Accepts one point and triangle every cycle (busy stays low) and returns its
// weights on done. The pipeline holds six setup stages for edge
// vectors, cross products and magnitudes, then a chain of 32 division cells,
// one quotient bit each, then a rounding and saturation register. Results
// cannot be held off; take them in the cycle done is high.
`timescale 1ns / 1ps
module triangle_barycentric_coords_unit import bcc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [FIELD_W-1:0]  ax,
  input  logic [FIELD_W-1:0]  ay,
  input  logic [FIELD_W-1:0]  bx,
  input  logic [FIELD_W-1:0]  by_coord,
  input  logic [FIELD_W-1:0]  cx,
  input  logic [FIELD_W-1:0]  cy,
  input  logic [FIELD_W-1:0]  px,
  input  logic [FIELD_W-1:0]  py,
  output logic                done,
  output logic [WEIGHT_W-1:0] weight_a,
  output logic [WEIGHT_W-1:0] weight_b,
  output logic [WEIGHT_W-1:0] weight_c,
  output logic                degenerate
);

  cell_t              lane_a, lane_b, lane_c;
  logic [LATENCY-1:0] vld;
  logic [STEPS:0]     deg_pipe;

  assign busy = 1'b0;

  bcc_front u_front (
    .clk(clk), .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord),
    .cx(cx), .cy(cy), .px(px), .py(py),
    .lane_a(lane_a), .lane_b(lane_b), .lane_c(lane_c)
  );

  bcc_div_lane u_lane_a (.clk(clk), .seed(lane_a), .weight(weight_a));
  bcc_div_lane u_lane_b (.clk(clk), .seed(lane_b), .weight(weight_b));
  bcc_div_lane u_lane_c (.clk(clk), .seed(lane_c), .weight(weight_c));

  // Track each transfer through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start};
    end
  end

  // Degenerate flag follows the lane seed to the output register
  always_ff @(posedge clk) begin
    deg_pipe <= {deg_pipe[STEPS-1:0], lane_a.deg};
  end

  assign done       = vld[LATENCY-1];
  assign degenerate = deg_pipe[STEPS];

endmodule

[hw/rtl/bcc_checker.sv]
// Port-level checks for the barycentric coordinate unit, bound to the top.
`timescale 1ns / 1ps
module bcc_checker import bcc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [WEIGHT_W-1:0] weight_a,
  input logic [WEIGHT_W-1:0] weight_b,
  input logic [WEIGHT_W-1:0] weight_c,
  input logic                degenerate
);

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (weight_a == '0 && weight_b == '0 && weight_c == '0))
    else $error("degenerate result with nonzero weights");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!start) |-> ##LATENCY (!done || $past(rst, LATENCY - 1)))
    else $error("result without a transfer");

endmodule

bind triangle_barycentric_coords_unit bcc_checker u_bcc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
  .degenerate(degenerate)
);

[sim/tb_triangle_barycentric_coords_unit.sv]
// Testbench for the barycentric coordinate unit: random and corner triangles checked against a model.
`timescale 1ns / 1ps
module tb_triangle_barycentric_coords_unit;
  import bcc_pkg::*;

  typedef struct {
    logic [FIELD_W-1:0] c [8];
  } tri_pt_t;

  typedef struct {
    logic [WEIGHT_W-1:0] wa, wb, wc;
    logic                deg;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [FIELD_W-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0;
  logic [FIELD_W-1:0] cx = '0, cy = '0, px = '0, py = '0;
  logic done;
  logic [WEIGHT_W-1:0] weight_a, weight_b, weight_c;
  logic degenerate;

  tri_pt_t  pending_pts[$];
  weights_t expected_weights[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  bit       stim_done = 1'b0;
  bit       hold_off = 1'b0;

  triangle_barycentric_coords_unit u_dut (.*);

  // Generate clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint coord_val(logic [FIELD_W-1:0] v);
    logic [COORD_BITS-1:0] m;
    m = v[COORD_BITS-1:0];
    return longint'($signed(m));
  endfunction

  // Exact quotient num/den scaled by 2^FRAC_BITS, rounded half away, saturated
  function automatic logic [WEIGHT_W-1:0] scaled_quotient(longint num, longint den);
    bit      neg;
    longint  un, ud, q, r;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = un / ud;
    if (q >= (longint'(1) << (31 - FRAC_BITS)))
      return neg ? SAT_NEG : SAT_POS;
    r = un % ud;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
    end
    if ((r << 1) >= ud) q = q + 1;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return WEIGHT_W'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return WEIGHT_W'(q);
  endfunction

  function automatic weights_t barycentric_weights(tri_pt_t t);
    weights_t w;
    longint v[8];
    longint e0x, e0y, e1x, e1y, e2x, e2y, den, nb, nc;
    for (int i = 0; i < 8; i++) v[i] = coord_val(t.c[i]);
    e0x = v[2] - v[0]; e0y = v[3] - v[1];
    e1x = v[4] - v[0]; e1y = v[5] - v[1];
    e2x = v[6] - v[0]; e2y = v[7] - v[1];
    den = e0x * e1y - e0y * e1x;
    nb  = e2x * e1y - e2y * e1x;
    nc  = e0x * e2y - e0y * e2x;
    if (den == 0) begin
      w.wa = '0; w.wb = '0; w.wc = '0; w.deg = 1'b1;
    end else begin
      w.wa = scaled_quotient(den - nb - nc, den);
      w.wb = scaled_quotient(nb, den);
      w.wc = scaled_quotient(nc, den);
      w.deg = 1'b0;
    end
    return w;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return FIELD_W'($urandom);
      1: return FIELD_W'($urandom_range(0, 15) - 8);
      2: return FIELD_W'($urandom_range(0, 511) - 256);
      default: return $urandom_range(0, 1) ? 16'h7FFF - FIELD_W'($urandom_range(0, 3))
                                           : 16'h8000 + FIELD_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic add_pts(input logic [FIELD_W-1:0] a0, a1, b0, b1, c0, c1, p0, p1);
    tri_pt_t t;
    t.c = '{a0, a1, b0, b1, c0, c1, p0, p1};
    pending_pts.push_back(t);
  endtask

  // Drive one transfer per accepted edge
  always @(posedge clk) begin
    tri_pt_t t;
    if (!rst) begin
      if (start && !busy) begin
        expected_weights.push_back(barycentric_weights(pending_pts.pop_front()));
      end
      if (pending_pts.size() > 0 && !hold_off &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        t = pending_pts[0];
        start <= 1'b1;
        {ax, ay, bx, by_coord} <= {t.c[0], t.c[1], t.c[2], t.c[3]};
        {cx, cy, px, py} <= {t.c[4], t.c[5], t.c[6], t.c[7]};
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    weights_t w;
    if (!rst && done) begin
      if (expected_weights.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        w = expected_weights.pop_front();
        if (weight_a !== w.wa) begin
          $error("weight_a expected %h actual %h", w.wa, weight_a); fail_count++;
        end
        if (weight_b !== w.wb) begin
          $error("weight_b expected %h actual %h", w.wb, weight_b); fail_count++;
        end
        if (weight_c !== w.wc) begin
          $error("weight_c expected %h actual %h", w.wc, weight_c); fail_count++;
        end
        if (degenerate !== w.deg) begin
          $error("degenerate expected %b actual %b", w.deg, degenerate); fail_count++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_pts.size() > 0 || start) @(posedge clk);
    while (expected_weights.size() > 0) @(posedge clk);
  endtask

  // Build stimulus phase by phase
  initial begin
    int pct[4] = '{0, 62, 0, 36};
    int m;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Corner cases: unit triangle, extremes, degenerate, saturation, ties
    add_pts(0, 0, 16'd1, 0, 0, 16'd1, 0, 0);
    add_pts(0, 0, 16'd1, 0, 0, 16'd1, 16'd1, 16'd1);
    add_pts(0, 0, 16'd3, 0, 0, 16'd3, 16'd1, 16'd1);
    add_pts(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_pts(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    add_pts(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    add_pts(0, 0, 0, 0, 0, 0, 16'd5, 16'd5);
    add_pts(0, 0, 16'd2, 16'd2, 16'd4, 16'd4, 16'd1, 16'd7);
    add_pts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pts(0, 0, 16'd1, 0, 0, 16'd1, 16'h7FFF, 16'h7FFF);
    add_pts(0, 0, 16'd1, 0, 0, 16'd1, 16'h8000, 16'h8000);
    add_pts(0, 0, 16'd1, 0, 0, 16'd1, 16'd200, 16'h8000);
    add_pts(0, 0, 16'd2, 0, 0, 16'd2, 16'd1, 0);
    add_pts(0, 0, 16'h7FFF, 0, 0, 16'h7FFF, 16'd1, 16'd1);
    add_pts(0, 0, 0, 16'd1, 16'd1, 0, 16'd1, 16'd1);
    add_pts(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0);
    drain();
    // Pause with no transfers before the random phases
    hold_off = 1'b1;
    repeat (50) @(posedge clk);
    hold_off = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct[ph];
      for (int i = 0; i < 285; i++) begin
        m = $urandom_range(0, 9);
        if (m < 2)
          add_pts(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                  rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0));
        else if (m < 7)
          add_pts(rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
                  rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2));
        else if (m < 9)
          add_pts(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                  rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
        else
          add_pts(rand_coord(3), rand_coord(3), rand_coord(3), rand_coord(3),
                  rand_coord(3), rand_coord(3), rand_coord(0), rand_coord(0));
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_weights.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
